>>> design/trvm_pkg.sv
// shared types and codes for the two-register vm execution unit
package trvm_pkg;

    localparam int unsigned XLEN = 32;
    localparam logic [XLEN-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        F_ADD_C     = 5'd0,
        F_SMUL_C    = 5'd1,
        F_ADD       = 5'd2,
        F_SUB       = 5'd3,
        F_SUB_ALT   = 5'd4,
        F_SMUL      = 5'd5,
        F_AND       = 5'd6,
        F_OR        = 5'd7,
        F_XOR       = 5'd8,
        F_NOT       = 5'd9,
        F_NEG       = 5'd10,
        F_INVERT    = 5'd11,
        F_SHL       = 5'd12,
        F_SHR       = 5'd13,
        F_SSHR      = 5'd14,
        F_SHL_C     = 5'd15,
        F_SDIV      = 5'd16,
        F_EQ_C      = 5'd17,
        F_COMPARE   = 5'd18,
        F_JCMP      = 5'd19,
        F_CONST     = 5'd20,
        F_ZERO      = 5'd21,
        F_INC       = 5'd22,
        F_DEC       = 5'd23,
        F_MOVE      = 5'd24,
        F_XCHG      = 5'd25,
        F_IDXADDR   = 5'd26,
        F_STRADJUST = 5'd27,
        F_BOUNDS    = 5'd28
    } func_t;

    typedef enum logic [2:0] {
        C_ZERO    = 3'd0,
        C_NOTZERO = 3'd1,
        C_EQ      = 3'd2,
        C_NEQ     = 3'd3,
        C_SLESS   = 3'd4,
        C_SLEQ    = 3'd5,
        C_SGRTR   = 3'd6,
        C_SGEQ    = 3'd7
    } cond_t;

    typedef enum logic [1:0] {
        FLT_NONE     = 2'd0,
        FLT_DIV_ZERO = 2'd1,
        FLT_OVERFLOW = 2'd2,
        FLT_BOUNDS   = 2'd3
    } fault_t;

    // outcome of one operation
    typedef struct packed {
        logic [XLEN-1:0] pri;
        logic [XLEN-1:0] alt;
        logic            jump;
        logic [1:0]      fault;
    } res_t;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

>>> design/trvm_muldiv.sv
// iterative multiply and signed divide around one shared 33-bit adder
module trvm_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  trvm_pkg::md_req_t              req,
    input  logic [trvm_pkg::XLEN-1:0]      op_a,
    input  logic [trvm_pkg::XLEN-1:0]      op_b,
    output logic                           done,
    output logic [trvm_pkg::XLEN-1:0]      res_lo,
    output logic [trvm_pkg::XLEN-1:0]      res_hi
);

    localparam int unsigned CW = $clog2(trvm_pkg::XLEN);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [trvm_pkg::XLEN-1:0] acc_reg, acc_next;
    logic [trvm_pkg::XLEN-1:0] dvs_reg, dvs_next;
    logic [trvm_pkg::XLEN-1:0] quo_reg, quo_next;
    logic                      div_reg, div_next;
    logic                      neg_q_reg, neg_q_next;
    logic                      neg_r_reg, neg_r_next;

    logic [trvm_pkg::XLEN:0]   rem_sh;
    logic [trvm_pkg::XLEN:0]   add_a;
    logic [trvm_pkg::XLEN:0]   add_b;
    logic [trvm_pkg::XLEN:0]   sum;
    logic [trvm_pkg::XLEN-1:0] mag_a;
    logic [trvm_pkg::XLEN-1:0] mag_b;

    // the shared adder: subtract for a restoring divide step, add for shift-add multiply
    always_comb
    begin
        rem_sh = {acc_reg, quo_reg[trvm_pkg::XLEN-1]};
        add_a  = div_reg ? rem_sh : {1'b0, acc_reg};
        if (div_reg)
        begin
            add_b = ~{1'b0, dvs_reg};
        end
        else if (quo_reg[0])
        begin
            add_b = {1'b0, dvs_reg};
        end
        else
        begin
            add_b = '0;
        end
        sum = add_a + add_b + {{trvm_pkg::XLEN{1'b0}}, div_reg};
    end

    always_comb
    begin
        mag_a = (req.is_div && op_a[trvm_pkg::XLEN-1]) ? (~op_a + 1'b1) : op_a;
        mag_b = (req.is_div && op_b[trvm_pkg::XLEN-1]) ? (~op_b + 1'b1) : op_b;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        acc_next   = acc_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            acc_next   = '0;
            div_next   = req.is_div;
            // divide: quo holds the dividend magnitude, dvs the divisor magnitude
            // multiply: quo holds the multiplier, dvs the multiplicand
            quo_next   = req.is_div ? mag_a : op_b;
            dvs_next   = req.is_div ? mag_b : op_a;
            neg_q_next = req.is_div && (op_a[trvm_pkg::XLEN-1] ^ op_b[trvm_pkg::XLEN-1]);
            neg_r_next = req.is_div && op_a[trvm_pkg::XLEN-1];
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!sum[trvm_pkg::XLEN])
                begin
                    acc_next = sum[trvm_pkg::XLEN-1:0];
                    quo_next = {quo_reg[trvm_pkg::XLEN-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[trvm_pkg::XLEN-1:0];
                    quo_next = {quo_reg[trvm_pkg::XLEN-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = sum[trvm_pkg::XLEN-1:0];
                dvs_next = {dvs_reg[trvm_pkg::XLEN-2:0], 1'b0};
                quo_next = {1'b0, quo_reg[trvm_pkg::XLEN-1:1]};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == CW'(trvm_pkg::XLEN - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        acc_reg   <= acc_next;
        dvs_reg   <= dvs_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done = done_reg;

    always_comb
    begin
        if (div_reg)
        begin
            res_lo = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
        else
        begin
            res_lo = acc_reg;
        end
        res_hi = neg_r_reg ? (~acc_reg + 1'b1) : acc_reg;
    end

endmodule

>>> design/trvm_alu.sv
// combinational operations, fault checks and operand steering for the multiply/divide unit
module trvm_alu (
    input  logic [4:0]                 func,
    input  logic [trvm_pkg::XLEN-1:0]  imm,
    input  logic                       use_alt,
    input  logic [2:0]                 cond,
    input  logic [trvm_pkg::XLEN-1:0]  pri,
    input  logic [trvm_pkg::XLEN-1:0]  alt,
    input  logic [trvm_pkg::XLEN-1:0]  md_lo,
    input  logic [trvm_pkg::XLEN-1:0]  md_hi,
    output logic                       md_go,
    output logic                       md_div,
    output logic [trvm_pkg::XLEN-1:0]  md_a,
    output logic [trvm_pkg::XLEN-1:0]  md_b,
    output trvm_pkg::res_t             res
);

    logic [trvm_pkg::XLEN-1:0] dst;
    logic [trvm_pkg::XLEN-1:0] dividend;
    logic [trvm_pkg::XLEN-1:0] divisor;
    logic [trvm_pkg::XLEN-1:0] str_sum;
    logic                      cond_ok;
    logic [1:0]                div_fault;

    always_comb
    begin
        dst      = use_alt ? alt : pri;
        dividend = use_alt ? alt : pri;
        divisor  = use_alt ? pri : alt;
        str_sum  = pri + 32'd4;

        if (divisor == '0)
        begin
            div_fault = trvm_pkg::FLT_DIV_ZERO;
        end
        else if (divisor == trvm_pkg::ALL_ONES && dividend == trvm_pkg::SIGN_BIT)
        begin
            div_fault = trvm_pkg::FLT_OVERFLOW;
        end
        else
        begin
            div_fault = trvm_pkg::FLT_NONE;
        end

        case (cond)
            trvm_pkg::C_ZERO:    cond_ok = (pri == '0);
            trvm_pkg::C_NOTZERO: cond_ok = (pri != '0);
            trvm_pkg::C_EQ:      cond_ok = (pri == alt);
            trvm_pkg::C_NEQ:     cond_ok = (pri != alt);
            trvm_pkg::C_SLESS:   cond_ok = ($signed(pri) < $signed(alt));
            trvm_pkg::C_SLEQ:    cond_ok = ($signed(pri) <= $signed(alt));
            trvm_pkg::C_SGRTR:   cond_ok = ($signed(pri) > $signed(alt));
            default:             cond_ok = ($signed(pri) >= $signed(alt));
        endcase
    end

    // multiply and divide go through the shared unit
    always_comb
    begin
        md_go  = 1'b0;
        md_div = 1'b0;
        md_a   = pri;
        md_b   = alt;
        case (func)
            trvm_pkg::F_SMUL_C:
            begin
                md_go = 1'b1;
                md_b  = imm;
            end
            trvm_pkg::F_SMUL:
            begin
                md_go = 1'b1;
            end
            trvm_pkg::F_SDIV:
            begin
                md_go  = (div_fault == trvm_pkg::FLT_NONE);
                md_div = 1'b1;
                md_a   = dividend;
                md_b   = divisor;
            end
            default:
            begin
                md_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.pri   = pri;
        res.alt   = alt;
        res.jump  = 1'b0;
        res.fault = trvm_pkg::FLT_NONE;
        case (func)
            trvm_pkg::F_ADD_C:     res.pri = pri + imm;
            trvm_pkg::F_SMUL_C:    res.pri = md_lo;
            trvm_pkg::F_ADD:       res.pri = pri + alt;
            trvm_pkg::F_SUB:       res.pri = pri - alt;
            trvm_pkg::F_SUB_ALT:   res.pri = alt - pri;
            trvm_pkg::F_SMUL:      res.pri = md_lo;
            trvm_pkg::F_AND:       res.pri = pri & alt;
            trvm_pkg::F_OR:        res.pri = pri | alt;
            trvm_pkg::F_XOR:       res.pri = pri ^ alt;
            trvm_pkg::F_NOT:       res.pri = {31'd0, (pri == '0)};
            trvm_pkg::F_NEG:       res.pri = ~pri + 1'b1;
            trvm_pkg::F_INVERT:    res.pri = ~pri;
            trvm_pkg::F_SHL:       res.pri = pri << alt[4:0];
            trvm_pkg::F_SHR:       res.pri = pri >> alt[4:0];
            trvm_pkg::F_SSHR:      res.pri = $signed(pri) >>> alt[4:0];
            trvm_pkg::F_SHL_C:
            begin
                if (use_alt)
                begin
                    res.alt = alt << imm[4:0];
                end
                else
                begin
                    res.pri = pri << imm[4:0];
                end
            end
            trvm_pkg::F_SDIV:
            begin
                res.fault = div_fault;
                if (div_fault == trvm_pkg::FLT_NONE)
                begin
                    res.pri = md_lo;
                    res.alt = md_hi;
                end
            end
            trvm_pkg::F_EQ_C:      res.pri = {31'd0, (dst == imm)};
            trvm_pkg::F_COMPARE:   res.pri = {31'd0, cond_ok};
            trvm_pkg::F_JCMP:      res.jump = cond_ok;
            trvm_pkg::F_CONST:
            begin
                if (use_alt)
                begin
                    res.alt = imm;
                end
                else
                begin
                    res.pri = imm;
                end
            end
            trvm_pkg::F_ZERO:
            begin
                if (use_alt)
                begin
                    res.alt = '0;
                end
                else
                begin
                    res.pri = '0;
                end
            end
            trvm_pkg::F_INC:
            begin
                if (use_alt)
                begin
                    res.alt = alt + 1'b1;
                end
                else
                begin
                    res.pri = pri + 1'b1;
                end
            end
            trvm_pkg::F_DEC:
            begin
                if (use_alt)
                begin
                    res.alt = alt - 1'b1;
                end
                else
                begin
                    res.pri = pri - 1'b1;
                end
            end
            trvm_pkg::F_MOVE:
            begin
                if (use_alt)
                begin
                    res.alt = pri;
                end
                else
                begin
                    res.pri = alt;
                end
            end
            trvm_pkg::F_XCHG:
            begin
                res.pri = alt;
                res.alt = pri;
            end
            trvm_pkg::F_IDXADDR:   res.pri = alt + {pri[29:0], 2'b00};
            trvm_pkg::F_STRADJUST: res.pri = $signed(str_sum) >>> 2;
            trvm_pkg::F_BOUNDS:
            begin
                if (pri > imm)
                begin
                    res.fault = trvm_pkg::FLT_BOUNDS;
                end
            end
            default:
            begin
                res.pri = pri;
            end
        endcase
    end

endmodule

>>> design/two_register_vm_alu_top.sv
// top level: sequencer, primary/alternate registers and result register
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, func, imm,        | input
//          | use_alt, cond                         |
//  out     | out_valid, out_ready, pri_out,        | output
//          | alt_out, jump_taken, fault            |
//
// combinational operations pass from the exec state straight to the commit state
// multiply and divide: the exec state loads the shared unit, the wait state runs the 32 steps
// of the shared adder until done, then the commit state writes the result
// reset clears both registers to zero and empties the result register
// in_ready is high only while idle; a result not yet taken holds the
// sequencer before its registers are updated
module two_register_vm_alu_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [4:0]                 func,
    input  logic [31:0]                imm,
    input  logic                       use_alt,
    input  logic [2:0]                 cond,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                pri_out,
    output logic [31:0]                alt_out,
    output logic                       jump_taken,
    output logic [1:0]                 fault
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [trvm_pkg::XLEN-1:0] pri_reg, pri_next;
    logic [trvm_pkg::XLEN-1:0] alt_reg, alt_next;
    logic                      jump_reg, jump_next;
    logic [1:0]                fault_reg, fault_next;
    logic                      out_valid_reg, out_valid_next;
    logic [4:0]                func_reg;
    logic [trvm_pkg::XLEN-1:0] imm_reg;
    logic                      use_alt_reg;
    logic [2:0]                cond_reg;

    logic                      in_fire;
    logic                      commit;
    logic                      md_go;
    logic                      md_div;
    logic                      md_done;
    logic [trvm_pkg::XLEN-1:0] md_a;
    logic [trvm_pkg::XLEN-1:0] md_b;
    logic [trvm_pkg::XLEN-1:0] md_lo;
    logic [trvm_pkg::XLEN-1:0] md_hi;
    trvm_pkg::md_req_t         md_req;
    trvm_pkg::res_t            res;

    trvm_alu u_alu (
        .func    (func_reg),
        .imm     (imm_reg),
        .use_alt (use_alt_reg),
        .cond    (cond_reg),
        .pri     (pri_reg),
        .alt     (alt_reg),
        .md_lo   (md_lo),
        .md_hi   (md_hi),
        .md_go   (md_go),
        .md_div  (md_div),
        .md_a    (md_a),
        .md_b    (md_b),
        .res     (res)
    );

    trvm_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (md_a),
        .op_b   (md_b),
        .done   (md_done),
        .res_lo (md_lo),
        .res_hi (md_hi)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    // registers change only when the result slot is free, so they can feed the outputs
    assign commit   = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        md_req.start  = (state_reg == S_EXEC) && md_go;
        md_req.is_div = md_div;
    end

    always_comb
    begin
        state_next     = state_reg;
        pri_next       = pri_reg;
        alt_next       = alt_reg;
        jump_next      = jump_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = md_go ? S_WAIT : S_COMMIT;
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    if (res.fault == trvm_pkg::FLT_NONE)
                    begin
                        pri_next = res.pri;
                        alt_next = res.alt;
                    end
                    jump_next      = res.jump;
                    fault_next     = res.fault;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pri_reg       <= '0;
            alt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pri_reg       <= pri_next;
            alt_reg       <= alt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jump_reg  <= jump_next;
        fault_reg <= fault_next;
        if (in_fire)
        begin
            func_reg    <= func;
            imm_reg     <= imm;
            use_alt_reg <= use_alt;
            cond_reg    <= cond;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pri_out    = pri_reg;
    assign alt_out    = alt_reg;
    assign jump_taken = jump_reg;
    assign fault      = fault_reg;

endmodule
